>>> sv/bapag_pkg.sv
// ----------------------------------------------------------------------------
// bapag_pkg
// Shared types and constants for the box axis permute address generator.
// ----------------------------------------------------------------------------
package bapag_pkg;

    localparam int COORD_W = 11;
    localparam int IDX_W   = 30;
    localparam int BOX_W   = 33;
    localparam int CFG_IDX_W = 3;
    localparam int ORDER_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GRID_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH = 3'd5;

    // destination axis orders, first letter fastest
    localparam logic [ORDER_W-1:0] ORD_XYZ = 3'd0;
    localparam logic [ORDER_W-1:0] ORD_XZY = 3'd1;
    localparam logic [ORDER_W-1:0] ORD_YXZ = 3'd2;
    localparam logic [ORDER_W-1:0] ORD_YZX = 3'd3;
    localparam logic [ORDER_W-1:0] ORD_ZXY = 3'd4;
    localparam logic [ORDER_W-1:0] ORD_ZYX = 3'd5;

    typedef struct packed {
        logic load;   // input word accepted
        logic mul1;   // inner product stage
        logic mul2;   // outer product stage
        logic emit;   // move result to output register
    } t_ctl_cmd;

    typedef struct packed {
        logic box_empty;
        logic out_free;
    } t_ctl_sts;

endpackage

>>> sv/bapag_ctrl.sv
// ----------------------------------------------------------------------------
// bapag_ctrl
// Sequencer for one word: accept, two multiply steps, hand-off to output.
// ----------------------------------------------------------------------------
module bapag_ctrl import bapag_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // empty box drops the word
                    if (!i_sts.box_empty) begin
                        n_state = ST_MUL1;
                    end
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/bapag_dp.sv
// ----------------------------------------------------------------------------
// bapag_dp
// Configuration registers, box position counters, index arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module bapag_dp import bapag_pkg::*; #(
    parameter int AXIS_MAX     = 1024,
    parameter int ELEMENT_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [BOX_W-1:0]        i_cfg_data,
    input  logic [ELEMENT_BITS-1:0] i_element,
    input  t_ctl_cmd                i_cmd,
    output t_ctl_sts                o_sts,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [ELEMENT_BITS-1:0] o_element_out,
    output logic [IDX_W-1:0]        o_source_index,
    output logic [IDX_W-1:0]        o_dest_index,
    output logic                    o_box_done
);

    // index = a + g1 * (b + g2 * c)
    typedef struct packed {
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] g1;
        logic [COORD_W-1:0] b;
        logic [COORD_W-1:0] g2;
        logic [COORD_W-1:0] c;
    } t_lane;

    localparam int M1_W  = 2 * COORD_W;
    localparam int SUM_W = M1_W + 1;
    localparam int PR_W  = COORD_W + SUM_W;

    logic [COORD_W-1:0] r_grid_x, r_grid_y, r_grid_z;
    logic [ORDER_W-1:0] r_order;
    logic [BOX_W-1:0]   r_box_low, r_box_high;
    logic [COORD_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic               r_in_pass;

    t_lane                   r_src, r_dst;
    logic [M1_W-1:0]         r_m1_src, r_m1_dst;
    logic [IDX_W-1:0]        r_prod_src, r_prod_dst;
    logic [ELEMENT_BITS-1:0] r_elem;
    logic                    r_done;
    logic                    r_out_valid;
    logic [ELEMENT_BITS-1:0] r_out_elem;
    logic [IDX_W-1:0]        r_out_src, r_out_dst;
    logic                    r_out_done;

    logic [COORD_W-1:0] lx, ly, lz, hx, hy, hz;
    logic [COORD_W-1:0] cx, cy, cz;
    logic [COORD_W:0]   cx_inc, cy_inc, cz_inc;
    logic               x_wrap, y_wrap, z_wrap, w_done;
    logic [COORD_W-1:0] n_pos_x, n_pos_y, n_pos_z;
    t_lane              n_src, n_dst;
    logic [SUM_W-1:0]   w_sum_src, w_sum_dst;
    logic [PR_W-1:0]    w_prod_src, w_prod_dst;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        r = v;
        if (32'(v) > AXIS_MAX) begin
            r = COORD_W'(AXIS_MAX);
        end
        return r;
    endfunction

    assign lx = sat_coord(r_box_low[10:0]);
    assign ly = sat_coord(r_box_low[21:11]);
    assign lz = sat_coord(r_box_low[32:22]);
    assign hx = sat_coord(r_box_high[10:0]);
    assign hy = sat_coord(r_box_high[21:11]);
    assign hz = sat_coord(r_box_high[32:22]);

    assign o_sts.box_empty = (lx >= hx) || (ly >= hy) || (lz >= hz);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // coordinate of this word and the next one
    always_comb begin
        cx = r_in_pass ? r_pos_x : lx;
        cy = r_in_pass ? r_pos_y : ly;
        cz = r_in_pass ? r_pos_z : lz;
        cx_inc = {1'b0, cx} + 1'b1;
        cy_inc = {1'b0, cy} + 1'b1;
        cz_inc = {1'b0, cz} + 1'b1;
        x_wrap = cx_inc >= {1'b0, hx};
        y_wrap = cy_inc >= {1'b0, hy};
        z_wrap = cz_inc >= {1'b0, hz};
        w_done = x_wrap && y_wrap && z_wrap;
        n_pos_x = x_wrap ? lx : cx_inc[COORD_W-1:0];
        n_pos_y = cy;
        n_pos_z = cz;
        if (x_wrap) begin
            n_pos_y = y_wrap ? ly : cy_inc[COORD_W-1:0];
            if (y_wrap) begin
                n_pos_z = z_wrap ? lz : cz_inc[COORD_W-1:0];
            end
        end
    end

    // operand routing per axis order
    always_comb begin
        n_src = '{a: cx, g1: r_grid_x, b: cy, g2: r_grid_y, c: cz};
        case (r_order)
            ORD_XZY: n_dst = '{a: cx, g1: r_grid_x, b: cz, g2: r_grid_z, c: cy};
            ORD_YXZ: n_dst = '{a: cy, g1: r_grid_y, b: cx, g2: r_grid_x, c: cz};
            ORD_YZX: n_dst = '{a: cy, g1: r_grid_y, b: cz, g2: r_grid_z, c: cx};
            ORD_ZXY: n_dst = '{a: cz, g1: r_grid_z, b: cx, g2: r_grid_x, c: cy};
            ORD_ZYX: n_dst = '{a: cz, g1: r_grid_z, b: cy, g2: r_grid_y, c: cx};
            default: n_dst = n_src;
        endcase
    end

    assign w_sum_src  = SUM_W'(r_src.b) + SUM_W'(r_m1_src);
    assign w_sum_dst  = SUM_W'(r_dst.b) + SUM_W'(r_m1_dst);
    assign w_prod_src = PR_W'(r_src.g1) * PR_W'(w_sum_src);
    assign w_prod_dst = PR_W'(r_dst.g1) * PR_W'(w_sum_dst);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_x    <= COORD_W'(1);
            r_grid_y    <= COORD_W'(1);
            r_grid_z    <= COORD_W'(1);
            r_order     <= ORD_XYZ;
            r_box_low   <= '0;
            r_box_high  <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_in_pass   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (o_sts.box_empty) begin
                    r_in_pass <= 1'b0;
                end else begin
                    r_pos_x   <= n_pos_x;
                    r_pos_y   <= n_pos_y;
                    r_pos_z   <= n_pos_z;
                    r_in_pass <= !w_done;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GRID_X:   r_grid_x <= i_cfg_data[COORD_W-1:0];
                    REG_GRID_Y:   r_grid_y <= i_cfg_data[COORD_W-1:0];
                    REG_GRID_Z:   r_grid_z <= i_cfg_data[COORD_W-1:0];
                    REG_AXIS_ORD: r_order  <= i_cfg_data[ORDER_W-1:0];
                    REG_BOX_LOW: begin
                        r_box_low <= i_cfg_data;
                        r_in_pass <= 1'b0;
                    end
                    REG_BOX_HIGH: begin
                        r_box_high <= i_cfg_data;
                        r_in_pass  <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src  <= n_src;
            r_dst  <= n_dst;
            r_elem <= i_element;
            r_done <= w_done;
        end
        if (i_cmd.mul1) begin
            r_m1_src <= M1_W'(r_src.g2) * M1_W'(r_src.c);
            r_m1_dst <= M1_W'(r_dst.g2) * M1_W'(r_dst.c);
        end
        if (i_cmd.mul2) begin
            r_prod_src <= w_prod_src[IDX_W-1:0];
            r_prod_dst <= w_prod_dst[IDX_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_elem <= r_elem;
            r_out_src  <= IDX_W'(r_src.a) + r_prod_src;
            r_out_dst  <= IDX_W'(r_dst.a) + r_prod_dst;
            r_out_done <= r_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_element_out  = r_out_elem;
    assign o_source_index = r_out_src;
    assign o_dest_index   = r_out_dst;
    assign o_box_done     = r_out_done;

endmodule

>>> sv/box_axis_permute_address_gen_core.sv
// ----------------------------------------------------------------------------
// box_axis_permute_address_gen_core
// Walks a box of a 3-D grid in x-fastest order and tags each element word
// with its source index and its index under the selected axis order.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_element        | sink
//  out     | o_out_valid, i_out_ready, o_element_out, | source
//          | o_source_index, o_dest_index, o_box_done |
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data          | write only
//
// A word passes through accept, inner multiply, outer multiply and hand-off.
// Each index needs two chained multiplies; hand-off waits for a free output.
// A finished word waits in the output register while the next is accepted.
// A word that arrives while the box is empty is taken and dropped.
// Synchronous active-low reset; no clearing pass.
module box_axis_permute_address_gen_core import bapag_pkg::*; #(
    parameter int AXIS_MAX     = 1024,
    parameter int ELEMENT_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [BOX_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [ELEMENT_BITS-1:0] i_element,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ELEMENT_BITS-1:0] o_element_out,
    output logic [IDX_W-1:0]        o_source_index,
    output logic [IDX_W-1:0]        o_dest_index,
    output logic                    o_box_done
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    bapag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bapag_dp #(
        .AXIS_MAX     (AXIS_MAX),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_element      (i_element),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_element_out  (o_element_out),
        .o_source_index (o_source_index),
        .o_dest_index   (o_dest_index),
        .o_box_done     (o_box_done)
    );

endmodule
